@@ hw/rtl/tla_pkg.sv @@
// shared types, byte codes and decode functions for the terminal line assembler
package tla_pkg;

  localparam int LINE_CAP_DEF = 32;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_A   = 8'h41;
  localparam logic [7:0] CH_D   = 8'h44;
  localparam logic [7:0] CH_LBR = 8'h5B;

  localparam logic [1:0] ESC_ARMED = 2'd2;
  localparam logic [1:0] ESC_MAX   = 2'd3;

  typedef enum logic [2:0] {
    KIND_ECHO  = 3'd0,
    KIND_LINE  = 3'd1,
    KIND_OVF   = 3'd2,
    KIND_ARROW = 3'd3,
    KIND_EMPTY = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } res_t;

  typedef enum logic [2:0] {
    CLS_PLAIN = 3'd0,
    CLS_BS    = 3'd1,
    CLS_CR    = 3'd2,
    CLS_ESC   = 3'd3,
    CLS_ARROW = 3'd4
  } cls_t;

  function automatic cls_t classify(input logic [7:0] c, input logic [1:0] esc);
    cls_t cls;
    unique case (c) inside
      CH_BS: cls = CLS_BS;
      CH_CR: cls = CLS_CR;
      CH_ESC, CH_LBR: cls = CLS_ESC;
      [CH_A:CH_D]: cls = (esc == ESC_ARMED) ? CLS_ARROW : CLS_PLAIN;
      default: cls = CLS_PLAIN;
    endcase
    return cls;
  endfunction

  function automatic logic [1:0] echo_count(input cls_t cls);
    logic [1:0] n;
    unique case (cls)
      CLS_BS:  n = 2'd3;
      CLS_CR:  n = 2'd2;
      CLS_ESC: n = 2'd0;
      default: n = 2'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] echo_byte(input cls_t cls, input logic [1:0] idx,
                                           input logic [7:0] c);
    logic [7:0] b;
    unique case (cls)
      CLS_BS:    b = (idx == 2'd1) ? CH_SP : CH_BS;
      CLS_CR:    b = (idx == 2'd0) ? CH_CR : CH_LF;
      CLS_ARROW: b = c - CH_A;
      default:   b = c;
    endcase
    return b;
  endfunction

endpackage

@@ hw/rtl/tla_ram.sv @@
// generic single-port-write, registered-read ram
module tla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/tla_ctrl.sv @@
// byte sequencer: stores into the line ram, tracks fill and escape state, emits results
module tla_ctrl #(
  parameter int LINE_CAP = tla_pkg::LINE_CAP_DEF,
  localparam int AW = $clog2(LINE_CAP),
  localparam int FW = $clog2(LINE_CAP + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    rx_byte,
  output logic          res_valid,
  input  logic          res_ready,
  output tla_pkg::res_t res,
  output logic [FW-1:0] fill_count,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data
);
  import tla_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_OVF   = 8'b0000_0010,
    S_ECHO  = 8'b0000_0100,
    S_TERM  = 8'b0000_1000,
    S_OVF2  = 8'b0001_0000,
    S_EMPTY = 8'b0010_0000,
    S_LRD   = 8'b0100_0000,
    S_LINE  = 8'b1000_0000
  } state_t;

  localparam logic [FW-1:0] CAP_F = FW'(LINE_CAP);
  localparam logic [FW-1:0] TWO_F = FW'(2);

  state_t        state, state_next;
  logic [FW-1:0] fill, fill_next;
  logic [1:0]    esc, esc_next;
  logic [7:0]    c, c_next;
  cls_t          cls, cls_next;
  logic [1:0]    ecnt, ecnt_next;
  logic [1:0]    eidx, eidx_next;
  logic [AW-1:0] lidx, lidx_next;

  logic          full;
  cls_t          cls_in;
  logic [FW-1:0] fill_st;
  logic [1:0]    n_in;
  logic          e_last;
  logic          l_last;
  logic          take;

  assign full    = (fill == CAP_F);
  assign cls_in  = classify(rx_byte, esc);
  assign fill_st = full ? '0 : fill + FW'(1);
  assign n_in    = echo_count(cls_in);
  assign e_last  = (eidx == 2'(ecnt - 2'd1));
  assign l_last  = ((FW'(lidx) + FW'(1)) == fill);
  assign take    = res_valid && res_ready;

  assign fill_count = fill;

  always_comb begin
    state_next = state;
    fill_next  = fill;
    esc_next   = esc;
    c_next     = c;
    cls_next   = cls;
    ecnt_next  = ecnt;
    eidx_next  = eidx;
    lidx_next  = lidx;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    res        = '{kind: KIND_ECHO, data: CH_NUL, last: 1'b0};
    wr_en      = 1'b0;
    wr_addr    = fill[AW-1:0];
    wr_data    = rx_byte;
    rd_en      = 1'b0;
    rd_addr    = lidx;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          wr_en     = !full;
          c_next    = rx_byte;
          cls_next  = cls_in;
          ecnt_next = n_in;
          eidx_next = '0;
          fill_next = fill_st;
          if (cls_in == CLS_BS) begin
            fill_next = (fill_st >= TWO_F) ? fill_st - TWO_F : '0;
          end
          if (cls_in == CLS_ESC && esc != ESC_MAX) begin
            esc_next = esc + 2'd1;
          end else if (cls_in == CLS_ARROW) begin
            esc_next = '0;
          end
          if (full) begin
            state_next = S_OVF;
          end else if (n_in != 2'd0) begin
            state_next = S_ECHO;
          end
        end
      end
      S_OVF: begin
        res_valid = 1'b1;
        res       = '{kind: KIND_OVF, data: CH_NUL, last: (ecnt == 2'd0)};
        if (take) begin
          state_next = (ecnt != 2'd0) ? S_ECHO : S_IDLE;
        end
      end
      S_ECHO: begin
        res_valid = 1'b1;
        res.kind  = (cls == CLS_ARROW) ? KIND_ARROW : KIND_ECHO;
        res.data  = echo_byte(cls, eidx, c);
        res.last  = e_last && (cls != CLS_CR);
        if (take) begin
          if (e_last) begin
            state_next = (cls == CLS_CR) ? S_TERM : S_IDLE;
          end else begin
            eidx_next = eidx + 2'd1;
          end
        end
      end
      S_TERM: begin
        lidx_next = '0;
        if (!full) begin
          wr_en      = 1'b1;
          wr_data    = CH_NUL;
          fill_next  = fill + FW'(1);
          state_next = S_LRD;
        end else begin
          fill_next  = '0;
          state_next = S_OVF2;
        end
      end
      S_OVF2: begin
        res_valid = 1'b1;
        res       = '{kind: KIND_OVF, data: CH_NUL, last: 1'b0};
        if (take) begin
          state_next = S_EMPTY;
        end
      end
      S_EMPTY: begin
        res_valid = 1'b1;
        res       = '{kind: KIND_EMPTY, data: CH_NUL, last: 1'b1};
        if (take) begin
          state_next = S_IDLE;
        end
      end
      S_LRD: begin
        rd_en      = 1'b1;
        state_next = S_LINE;
      end
      S_LINE: begin
        res_valid = 1'b1;
        res       = '{kind: KIND_LINE, data: rd_data, last: l_last};
        if (take) begin
          if (l_last) begin
            fill_next  = '0;
            state_next = S_IDLE;
          end else begin
            lidx_next = lidx + AW'(1);
            rd_en     = 1'b1;
            rd_addr   = lidx + AW'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      esc   <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      esc   <= esc_next;
    end
    c    <= c_next;
    cls  <= cls_next;
    ecnt <= ecnt_next;
    eidx <= eidx_next;
    lidx <= lidx_next;
  end

endmodule

@@ hw/rtl/tla_oreg.sv @@
// output register stage between the sequencer and the result port
module tla_oreg (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_ready,
  input  tla_pkg::res_t up_res,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    kind,
  output logic [7:0]    data,
  output logic          last
);
  import tla_pkg::*;

  res_t held;

  assign up_ready = !out_valid || out_ready;
  assign kind     = held.kind;
  assign data     = held.data;
  assign last     = held.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      held <= up_res;
    end
  end

endmodule

@@ hw/rtl/terminal_line_assembler.sv @@
// terminal line assembler top level
// the first result of a word reaches the output port through the sequencer state register and then the output register
// the sequencer emits one result per cycle while the output register accepts it, and takes no new word
// while results of the current word are pending; an overflow adds one more result
// line bytes stream from the line ram one per cycle while the output accepts them, behind a read-ahead state
// reset (rst, synchronous) clears fill count, escape counter, sequencer and output valid;
// the line ram is not cleared and needs no clearing pass
module terminal_line_assembler #(
  parameter int LINE_CAP = tla_pkg::LINE_CAP_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] kind,
  output logic [7:0] data,
  output logic       last
);
  import tla_pkg::*;

  localparam int AW = $clog2(LINE_CAP);
  localparam int FW = $clog2(LINE_CAP + 1);

  logic          res_valid;
  logic          res_ready;
  res_t          res;
  logic [FW-1:0] fill_count;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  tla_ctrl #(.LINE_CAP(LINE_CAP)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .fill_count (fill_count),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  tla_ram #(.WIDTH(8), .DEPTH(LINE_CAP)) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tla_oreg u_oreg (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (res_valid),
    .up_ready  (res_ready),
    .up_res    (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .data      (data),
    .last      (last)
  );

`ifndef NO_ASSERTIONS
  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && res_valid))
    else $error("sequencer presents a result while taking input");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FW'(LINE_CAP))
    else $error("fill count beyond line capacity");

  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready && res.last) |=> in_ready)
    else $error("sequencer not ready after final result of a word");
`endif

endmodule
